/* hw/rtl/fsp_pkg.sv */
// Package for the fixed slot pool allocator: codes, payload types and field widths.
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned AddrW     = 22;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned ItemW     = 13;
  localparam int unsigned CountW    = 11;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned SizeW     = 14;  // rounded slot size reaches 8192

  localparam logic [CfgIdxW-1:0] REG_ITEM_BYTES = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SLOT_COUNT = 1'd1;

  localparam logic [ItemW-1:0]  ITEM_BYTES_RST = 13'd4;
  localparam logic [CountW-1:0] SLOT_COUNT_RST = 11'd1024;

  typedef enum logic [FuncW-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OUTSIDE   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    func_e            func;
    logic [AddrW-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] slot_addr;
    status_e          status;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/fsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fsp_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fixed_slot_pool_allocator.sv */
// Top level of the fixed slot pool allocator: LIFO free stack in RAM plus fresh pointer.
//
//   channel   ports                               handshake
//   request   start, busy, req_i (func, addr)     taken when start && !busy
//   result    done_o, rsp_o (slot_addr, status)   one-cycle strobe, no back-pressure
//   config    cfg_we_i, cfg_idx_i, cfg_data_i     written when cfg_we_i is high
//
// Every item gives its result in the cycle after it is taken; one item per cycle.
// A pop reads the stack RAM at the accept edge, and its data leaves the RAM
// read register in the result cycle. Push and pop fall in different cycles,
// so a freed slot is visible to the next item. busy stays low.
// Reset clears the stack count and fresh pointer; the stack RAM needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module fixed_slot_pool_allocator #(
  parameter int unsigned MAX_SLOTS   = 1024,
  parameter int unsigned OFFSET_BITS = 22
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire fsp_pkg::req_t                 req_i,
  output logic                               done_o,
  output fsp_pkg::rsp_t                      rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [fsp_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned OW = OFFSET_BITS;
  localparam int unsigned AW = $clog2(MAX_SLOTS);
  // wide enough for size * capacity, 2^OW, and the fresh pointer past the end
  localparam int unsigned LW = ((OW > 25) ? OW : 25) + 1;
  localparam int unsigned CW = fsp_pkg::CountW;

  logic [fsp_pkg::ItemW-1:0] item_bytes_q;
  logic [CW-1:0]             slot_count_q;
  logic [CW-1:0]             stack_cnt_q, stack_cnt_d;
  logic [LW-1:0]             fresh_q, fresh_d;
  logic                      done_q, done_d;
  logic                      pop_q, pop_d;
  logic [fsp_pkg::AddrW-1:0] res_addr_q, res_addr_d;
  fsp_pkg::status_e          status_q, status_d;

  logic                      accept;
  logic [fsp_pkg::SizeW-1:0] slot_size;
  logic [CW-1:0]             cap;
  logic [LW-1:0]             prod, span, pool_end, addr_ext;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [OW-1:0]             ram_wdata, ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // pool geometry
  assign slot_size = (fsp_pkg::SizeW'(item_bytes_q) + fsp_pkg::SizeW'(3))
                     & ~fsp_pkg::SizeW'(3);
  assign cap       = (32'(slot_count_q) < MAX_SLOTS) ? slot_count_q : CW'(MAX_SLOTS);
  assign prod      = LW'(slot_size) * LW'(cap);
  assign span      = LW'(1) << OW;
  assign pool_end  = (prod < span) ? prod : span;
  assign addr_ext  = LW'(OW'(req_i.addr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_bytes_q <= fsp_pkg::ITEM_BYTES_RST;
      slot_count_q <= fsp_pkg::SLOT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fsp_pkg::REG_ITEM_BYTES: item_bytes_q <= cfg_data_i;
        fsp_pkg::REG_SLOT_COUNT: slot_count_q <= CW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    stack_cnt_d = stack_cnt_q;
    fresh_d     = fresh_q;
    done_d      = accept;
    pop_d       = 1'b0;
    res_addr_d  = '0;
    status_d    = fsp_pkg::ST_OK;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = AW'(stack_cnt_q);
    ram_raddr   = AW'(stack_cnt_q - CW'(1));
    ram_wdata   = OW'(req_i.addr);
    if (accept) begin
      unique case (req_i.func)
        fsp_pkg::FN_ALLOC: begin
          if (stack_cnt_q != '0) begin
            ram_re      = 1'b1;
            pop_d       = 1'b1;
            stack_cnt_d = stack_cnt_q - CW'(1);
          end else if (fresh_q < pool_end) begin
            res_addr_d = fsp_pkg::AddrW'(OW'(fresh_q));
            fresh_d    = fresh_q + LW'(slot_size);
          end else begin
            status_d = fsp_pkg::ST_EXHAUSTED;
          end
        end
        fsp_pkg::FN_FREE: begin
          if (addr_ext >= pool_end) begin
            status_d = fsp_pkg::ST_OUTSIDE;
          end else if (stack_cnt_q >= cap) begin
            status_d = fsp_pkg::ST_OVERFLOW;
          end else begin
            ram_we      = 1'b1;
            stack_cnt_d = stack_cnt_q + CW'(1);
          end
        end
        fsp_pkg::FN_CLEAR: begin
          stack_cnt_d = '0;
          fresh_d     = '0;
        end
        default: ;  // unused code: no change, ok with zero address
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_cnt_q <= '0;
      fresh_q     <= '0;
      done_q      <= 1'b0;
      pop_q       <= 1'b0;
    end else begin
      stack_cnt_q <= stack_cnt_d;
      fresh_q     <= fresh_d;
      done_q      <= done_d;
      pop_q       <= pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_addr_q <= res_addr_d;
    status_q   <= status_d;
  end

  fsp_ram #(
    .WIDTH (OW),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o          = done_q;
  assign rsp_o.slot_addr = pop_q ? fsp_pkg::AddrW'(ram_rdata) : res_addr_q;
  assign rsp_o.status    = status_q;

  // every taken item answers in the next cycle, and only then
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("item without result");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("result without item");
  // a failed item leaves the stack depth alone
  a_fail_keeps_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != fsp_pkg::ST_OK) |-> $stable(stack_cnt_q))
    else $error("stack depth moved on failed item");
  // a pop result comes with the stack one entry shorter
  a_pop_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_q |-> ($past(stack_cnt_q) == stack_cnt_q + CW'(1)))
    else $error("pop without stack decrement");

endmodule

`default_nettype wire

/* test/fsp_checker.sv */
// Checker for the fixed slot pool allocator: tracks pool state, predicts each result, compares.
`timescale 1ns / 1ps

module fsp_checker #(
  parameter int unsigned MaxSlots = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  fsp_pkg::req_t                req_i,
  input  logic                         done_i,
  input  fsp_pkg::rsp_t                rsp_i,
  input  logic                         cfg_we_i,
  input  logic [fsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fsp_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o
);

  // shadow of the allocator state
  logic [fsp_pkg::AddrW-1:0]  freed_slots [MaxSlots];
  int unsigned                freed_depth;
  longint unsigned            fresh_offset;
  logic [fsp_pkg::ItemW-1:0]  item_bytes_q;
  logic [fsp_pkg::CountW-1:0] slot_count_q;

  fsp_pkg::rsp_t expected_rsps [$];
  int unsigned   mismatches = 0;
  int unsigned   queued = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = queued;

  function automatic fsp_pkg::rsp_t predict_rsp(input fsp_pkg::req_t r);
    fsp_pkg::rsp_t   res;
    longint unsigned slot_sz;
    longint unsigned cap;
    longint unsigned pool_end;
    slot_sz = (longint'(item_bytes_q) + 3) & ~longint'(3);
    cap = (slot_count_q < MaxSlots) ? slot_count_q : MaxSlots;
    pool_end = slot_sz * cap;
    if (pool_end > (longint'(1) << fsp_pkg::AddrW)) pool_end = longint'(1) << fsp_pkg::AddrW;
    res.slot_addr = '0;
    res.status = fsp_pkg::ST_OK;
    unique case (r.func)
      fsp_pkg::FN_ALLOC: begin
        if (freed_depth > 0) begin
          freed_depth--;
          res.slot_addr = freed_slots[freed_depth];
        end else if (fresh_offset < pool_end) begin
          res.slot_addr = fsp_pkg::AddrW'(fresh_offset);
          fresh_offset += slot_sz;
        end else begin
          res.status = fsp_pkg::ST_EXHAUSTED;
        end
      end
      fsp_pkg::FN_FREE: begin
        if (r.addr >= pool_end) begin
          res.status = fsp_pkg::ST_OUTSIDE;
        end else if (freed_depth >= cap) begin
          res.status = fsp_pkg::ST_OVERFLOW;
        end else begin
          freed_slots[freed_depth] = r.addr;
          freed_depth++;
        end
      end
      fsp_pkg::FN_CLEAR: begin
        freed_depth = 0;
        fresh_offset = 0;
      end
      default: ;  // reserved code: no effect, zero answer
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("fsp_checker @%0t: %s mismatch, expected 0x%0h got 0x%0h",
               $realtime, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fsp_pkg::rsp_t want;
    if (!rst_ni) begin
      freed_depth = 0;
      fresh_offset = 0;
      item_bytes_q = fsp_pkg::ITEM_BYTES_RST;
      slot_count_q = fsp_pkg::SLOT_COUNT_RST;
      expected_rsps.delete();
      queued <= 0;
    end else begin
      if (done_i) begin
        if (expected_rsps.size() == 0) begin
          note_mismatch("unexpected result", 0, rsp_i);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.slot_addr !== want.slot_addr)
            note_mismatch("slot_addr", want.slot_addr, rsp_i.slot_addr);
          if (rsp_i.status !== want.status)
            note_mismatch("status", want.status, rsp_i.status);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == fsp_pkg::REG_ITEM_BYTES) begin
          item_bytes_q = fsp_pkg::ItemW'(cfg_data_i);
        end else if (cfg_idx_i == fsp_pkg::REG_SLOT_COUNT) begin
          slot_count_q = fsp_pkg::CountW'(cfg_data_i);
        end
      end
      if (start_i && !busy_i) expected_rsps.push_back(predict_rsp(req_i));
      queued <= expected_rsps.size();
    end
  end

endmodule

/* test/fixed_slot_pool_allocator_tb.sv */
// Testbench top for the fixed slot pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fixed_slot_pool_allocator_tb;

  localparam logic [fsp_pkg::FuncW-1:0] FnReserved = 2'd3;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned MaxSlots = 1024;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  fsp_pkg::req_t                req = '0;
  logic                         done;
  fsp_pkg::rsp_t                rsp;
  logic                         cfg_we = 1'b0;
  logic [fsp_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [fsp_pkg::CfgDataW-1:0] cfg_data = '0;
  int unsigned                  mismatch_count;
  int unsigned                  pending;
  int unsigned                  quiet_cycles = 0;

  fixed_slot_pool_allocator i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  fsp_checker #(.MaxSlots(MaxSlots)) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req),
    .done_i           (done),
    .rsp_i            (rsp),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[fixed_slot_pool_allocator] ERROR");
        $finish;
      end
    end
  end

  task automatic issue(input logic [fsp_pkg::FuncW-1:0] fn,
                       input logic [fsp_pkg::AddrW-1:0] a);
    start <= 1'b1;
    req <= fsp_pkg::req_t'({fn, a});
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and wait until every result is back, plus the pipeline latency
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_pool(input int unsigned item_bytes, input int unsigned slot_count);
    cfg_we <= 1'b1;
    cfg_idx <= fsp_pkg::REG_ITEM_BYTES;
    cfg_data <= fsp_pkg::CfgDataW'(item_bytes);
    @(posedge clk);
    cfg_idx <= fsp_pkg::REG_SLOT_COUNT;
    cfg_data <= fsp_pkg::CfgDataW'(slot_count);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned                 ib;
    int unsigned                 sc;
    int unsigned                 sz;
    int unsigned                 cap;
    int unsigned                 span;
    int unsigned                 n_items;
    int unsigned                 roll;
    int unsigned                 pick;
    logic [fsp_pkg::FuncW-1:0]   fn;
    logic [fsp_pkg::AddrW-1:0]   a;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default pool: 4-byte slots, 1024 of them
    issue(fsp_pkg::FN_ALLOC, '0);
    issue(fsp_pkg::FN_ALLOC, '1);
    issue(fsp_pkg::FN_FREE, 22'd0);
    issue(fsp_pkg::FN_FREE, 22'd4);
    issue(fsp_pkg::FN_ALLOC, '0);          // pop right behind a push
    issue(fsp_pkg::FN_ALLOC, '0);
    issue(fsp_pkg::FN_FREE, '1);           // far outside
    issue(fsp_pkg::FN_FREE, 22'd4096);     // exactly at pool end
    issue(fsp_pkg::FN_FREE, 22'd4092);     // last slot
    issue(FnReserved, '1);
    issue(fsp_pkg::FN_CLEAR, 22'h2AAAAA);
    issue(fsp_pkg::FN_ALLOC, 22'h155555);

    // one slot of one byte: exhaustion and stack overflow
    drain();
    program_pool(1, 1);
    issue(fsp_pkg::FN_CLEAR, '0);
    issue(fsp_pkg::FN_ALLOC, '0);
    issue(fsp_pkg::FN_ALLOC, '0);
    issue(fsp_pkg::FN_FREE, 22'd0);
    issue(fsp_pkg::FN_FREE, 22'd0);
    issue(fsp_pkg::FN_FREE, 22'd4);

    // empty pool; stack content from before survives the write
    drain();
    program_pool(0, 0);
    issue(fsp_pkg::FN_ALLOC, '0);
    issue(fsp_pkg::FN_ALLOC, '0);
    issue(fsp_pkg::FN_FREE, 22'd0);

    // widest slots, count beyond the stack depth
    drain();
    program_pool(8191, 2047);
    issue(fsp_pkg::FN_FREE, '1);
    issue(fsp_pkg::FN_ALLOC, '0);
    issue(fsp_pkg::FN_ALLOC, '0);

    for (int p = 0; p < 10; p++) begin
      unique case (p)
        0:       begin ib = 4096; sc = 1024; end
        1:       begin ib = 8191; sc = 2047; end
        2:       begin ib = 0;    sc = 8;    end
        3:       begin ib = 5;    sc = 0;    end
        default: begin ib = $urandom_range(1, 64); sc = $urandom_range(1, 12); end
      endcase
      n_items = (p < 4) ? 60 : 95;
      sz = (ib + 3) & ~32'd3;
      cap = (sc < MaxSlots) ? sc : MaxSlots;
      span = sz * cap;
      if (span > (32'd1 << fsp_pkg::AddrW)) span = 32'd1 << fsp_pkg::AddrW;

      drain();
      program_pool(ib, sc);
      if ($urandom_range(0, 1) == 1) issue(fsp_pkg::FN_CLEAR, fsp_pkg::AddrW'($urandom));

      for (int i = 0; i < n_items; i++) begin
        if (p == 6 && i == 40) drain();
        // phase 5 runs without gaps
        if (p != 5 && $urandom_range(0, 99) < 7) begin
          start <= 1'b0;
          @(posedge clk);
        end
        roll = $urandom_range(0, 99);
        a = fsp_pkg::AddrW'($urandom);
        if (roll < 45) begin
          fn = fsp_pkg::FN_ALLOC;
        end else if (roll < 88) begin
          fn = fsp_pkg::FN_FREE;
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            a = (cap == 0) ? '0 : fsp_pkg::AddrW'(sz * $urandom_range(0, cap - 1));
          end else if (pick == 6) begin
            a = fsp_pkg::AddrW'(span - 1);
          end else if (pick == 7) begin
            a = fsp_pkg::AddrW'(span);
          end
        end else if (roll < 93) begin
          fn = fsp_pkg::FN_CLEAR;
        end else begin
          fn = FnReserved;
        end
        issue(fn, a);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("[fixed_slot_pool_allocator] OK");
    end else begin
      $display("[fixed_slot_pool_allocator] ERROR");
    end
    $finish;
  end

endmodule
